// ----- src/hsv2rgb_pkg.sv -----
// Shared constants and types for the HSV to RGB converter.
package hsv2rgb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int HUE_W      = 25;
    localparam int FRAC_W     = FRAC_BITS + 1;          // 0..1 inclusive
    localparam int CH_W       = 8;
    localparam int IN_DATA_W  = HUE_W + 2 * FRAC_W;
    localparam int IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = 3 * CH_W;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

    localparam logic [FRAC_W-1:0] ONE = FRAC_W'(1) << FRAC_BITS;

    // hue/60 as hue/4/15; reciprocal of 15 exact for 23-bit dividends
    localparam int HUE_PRE_SHIFT = 2;
    localparam int HUE_N_W       = HUE_W - HUE_PRE_SHIFT;
    localparam int RECIP_SHIFT   = HUE_N_W + 4;
    localparam int RECIP_W       = 24;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd14) / 64'd15);
    localparam int PROD_W        = HUE_N_W + RECIP_W;
    localparam int HQ_W          = PROD_W - RECIP_SHIFT;
    localparam int INT_W         = HQ_W - FRAC_BITS;
    localparam logic [INT_W-1:0] SECTORS = INT_W'(6);

    localparam logic [CH_W-1:0] CH_MAX = CH_W'(255);

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } sector_t;

endpackage

// ----- src/hsv2rgb_hue_div.sv -----
// Hue divide by 60: registered reciprocal product, then sector (mod 6) and fraction.
module hsv2rgb_hue_div
(
    input  logic                               clk,
    input  logic                               en,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]      hue,
    output hsv2rgb_pkg::sector_t               sector,
    output logic [hsv2rgb_pkg::FRAC_BITS-1:0]  frac
);
    import hsv2rgb_pkg::*;

    logic [HUE_N_W-1:0] hue_n;
    logic [PROD_W-1:0]  prod;
    logic [HQ_W-1:0]    hq_reg;
    logic [INT_W-1:0]   int_part;
    logic [INT_W-1:0]   int_wrapped;

    assign hue_n = hue[HUE_W-1:HUE_PRE_SHIFT];
    assign prod  = PROD_W'(hue_n) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hq_reg <= prod[RECIP_SHIFT +: HQ_W];
        end
    end

    // integer part is at most 8, so one subtract wraps it
    assign int_part    = hq_reg[HQ_W-1:FRAC_BITS];
    assign int_wrapped = (int_part >= SECTORS) ? int_part - SECTORS : int_part;
    assign sector      = sector_t'(int_wrapped[2:0]);
    assign frac        = hq_reg[FRAC_BITS-1:0];

endmodule

// ----- src/hsv_to_rgb_fixed_point_core.sv -----
// HSV to RGB converter, top level: four-stage pipeline with stream ports.
//
// Converts one HSV pixel to 8-bit RGB per clock cycle while the output is not
// stalled. Stage one multiplies hue by a reciprocal of 60 and clamps
// saturation and brightness to one; stage two forms the sector, s*f, s*(1-f)
// and p; stage three forms q and t; stage four picks v, p, q or t per channel
// and scales by 255 into the output register. Every multiplier is followed by
// a register. Each stage has its own valid bit and enable, so bubbles close up
// and a stall at the output holds every word in place.
module hsv_to_rgb_fixed_point_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // hue [24:0], saturation [41:25], brightness [58:42], zero fill above
    input  logic [hsv2rgb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    output logic [hsv2rgb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import hsv2rgb_pkg::*;

    logic [3:0]           vld_reg;
    logic [3:0]           en;

    logic [HUE_W-1:0]     in_hue;
    logic [FRAC_W-1:0]    in_s;
    logic [FRAC_W-1:0]    in_v;

    logic [FRAC_W-1:0]    s1_s_reg;
    logic [FRAC_W-1:0]    s1_v_reg;
    sector_t              s1_sector;
    logic [FRAC_BITS-1:0] s1_frac;

    logic [2*FRAC_W-1:0]  sf_prod;
    logic [2*FRAC_W-1:0]  st_prod;
    logic [2*FRAC_W-1:0]  p_prod;
    sector_t              s2_sector_reg;
    logic [FRAC_W-1:0]    s2_v_reg;
    logic [FRAC_W-1:0]    s2_sf_reg;
    logic [FRAC_W-1:0]    s2_st_reg;
    logic [FRAC_W-1:0]    s2_p_reg;

    logic [2*FRAC_W-1:0]  q_prod;
    logic [2*FRAC_W-1:0]  t_prod;
    sector_t              s3_sector_reg;
    logic [FRAC_W-1:0]    s3_v_reg;
    logic [FRAC_W-1:0]    s3_p_reg;
    logic [FRAC_W-1:0]    s3_q_reg;
    logic [FRAC_W-1:0]    s3_t_reg;

    logic [FRAC_W-1:0]    sel_r;
    logic [FRAC_W-1:0]    sel_g;
    logic [FRAC_W-1:0]    sel_b;
    logic [FRAC_W+CH_W-1:0] r_prod;
    logic [FRAC_W+CH_W-1:0] g_prod;
    logic [FRAC_W+CH_W-1:0] b_prod;
    logic [CH_W-1:0]      red_reg;
    logic [CH_W-1:0]      green_reg;
    logic [CH_W-1:0]      blue_reg;

    // a stage loads when empty or when the stage after it moves on
    assign en[3] = !vld_reg[3] || m_axis_tready;
    assign en[2] = !vld_reg[2] || en[3];
    assign en[1] = !vld_reg[1] || en[2];
    assign en[0] = !vld_reg[0] || en[1];

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld_reg[3];
    assign m_axis_tdata  = OUT_TDATA_W'({blue_reg, green_reg, red_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0]) vld_reg[0] <= s_axis_tvalid;
            if (en[1]) vld_reg[1] <= vld_reg[0];
            if (en[2]) vld_reg[2] <= vld_reg[1];
            if (en[3]) vld_reg[3] <= vld_reg[2];
        end
    end

    // stage 1
    assign in_hue = s_axis_tdata[HUE_W-1:0];
    assign in_s   = s_axis_tdata[HUE_W +: FRAC_W];
    assign in_v   = s_axis_tdata[HUE_W+FRAC_W +: FRAC_W];

    hsv2rgb_hue_div u_hue_div
    (
        .clk    (clk),
        .en     (en[0]),
        .hue    (in_hue),
        .sector (s1_sector),
        .frac   (s1_frac)
    );

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_s_reg <= (in_s > ONE) ? ONE : in_s;
            s1_v_reg <= (in_v > ONE) ? ONE : in_v;
        end
    end

    // stage 2
    assign sf_prod = (2*FRAC_W)'(s1_s_reg) * (2*FRAC_W)'(s1_frac);
    assign st_prod = (2*FRAC_W)'(s1_s_reg) * (2*FRAC_W)'(ONE - FRAC_W'(s1_frac));
    assign p_prod  = (2*FRAC_W)'(s1_v_reg) * (2*FRAC_W)'(ONE - s1_s_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_sector_reg <= s1_sector;
            s2_v_reg      <= s1_v_reg;
            s2_sf_reg     <= sf_prod[FRAC_BITS +: FRAC_W];
            s2_st_reg     <= st_prod[FRAC_BITS +: FRAC_W];
            s2_p_reg      <= p_prod[FRAC_BITS +: FRAC_W];
        end
    end

    // stage 3
    assign q_prod = (2*FRAC_W)'(s2_v_reg) * (2*FRAC_W)'(ONE - s2_sf_reg);
    assign t_prod = (2*FRAC_W)'(s2_v_reg) * (2*FRAC_W)'(ONE - s2_st_reg);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_sector_reg <= s2_sector_reg;
            s3_v_reg      <= s2_v_reg;
            s3_p_reg      <= s2_p_reg;
            s3_q_reg      <= q_prod[FRAC_BITS +: FRAC_W];
            s3_t_reg      <= t_prod[FRAC_BITS +: FRAC_W];
        end
    end

    // stage 4
    always_comb
    begin
        case (s3_sector_reg)
            SEC_RY:
            begin
                sel_r = s3_v_reg; sel_g = s3_t_reg; sel_b = s3_p_reg;
            end
            SEC_YG:
            begin
                sel_r = s3_q_reg; sel_g = s3_v_reg; sel_b = s3_p_reg;
            end
            SEC_GC:
            begin
                sel_r = s3_p_reg; sel_g = s3_v_reg; sel_b = s3_t_reg;
            end
            SEC_CB:
            begin
                sel_r = s3_p_reg; sel_g = s3_q_reg; sel_b = s3_v_reg;
            end
            SEC_BM:
            begin
                sel_r = s3_t_reg; sel_g = s3_p_reg; sel_b = s3_v_reg;
            end
            default:
            begin
                sel_r = s3_v_reg; sel_g = s3_p_reg; sel_b = s3_q_reg;
            end
        endcase
    end

    assign r_prod = (FRAC_W+CH_W)'(sel_r) * (FRAC_W+CH_W)'(CH_MAX);
    assign g_prod = (FRAC_W+CH_W)'(sel_g) * (FRAC_W+CH_W)'(CH_MAX);
    assign b_prod = (FRAC_W+CH_W)'(sel_b) * (FRAC_W+CH_W)'(CH_MAX);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            red_reg   <= r_prod[FRAC_BITS +: CH_W];
            green_reg <= g_prod[FRAC_BITS +: CH_W];
            blue_reg  <= b_prod[FRAC_BITS +: CH_W];
        end
    end

endmodule
